// ===== rtl/fol_pkg.sv =====
package fol_pkg;

    // Input opcodes
    localparam logic [1:0] OPC_LOAD   = 2'd0;
    localparam logic [1:0] OPC_ACCESS = 2'd1;
    localparam logic [1:0] OPC_DUMP   = 2'd2;

    // Result status codes
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_MISS  = 2'd1;
    localparam logic [1:0] STS_FULL  = 2'd2;
    localparam logic [1:0] STS_EMPTY = 2'd3;

    // Most results one dump gives
    localparam int MAX_OUT = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_SEEK,
        ST_PLACE,
        ST_DUMP
    } state_t;

    // What the whole chain does in one cycle
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_ROTATE,
        OP_LOAD,
        OP_PLACE
    } chain_op_t;

    // Where one cell takes its next entry from
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_FROM_PREV,
        CMD_FROM_NEXT,
        CMD_FROM_HEAD,
        CMD_FROM_NEW
    } cell_cmd_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  status;
        logic [31:0] value;
        logic [15:0] count;
        logic [5:0]  position;
        logic        last;
    } result_t;

endpackage

// ===== rtl/fol_cell.sv =====
module fol_cell #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                    clk,
    input  fol_pkg::cell_cmd_t      cmd,
    input  logic [31:0]             prev_value,
    input  logic [COUNT_WIDTH-1:0]  prev_count,
    input  logic [31:0]             prev_stamp,
    input  logic [31:0]             next_value,
    input  logic [COUNT_WIDTH-1:0]  next_count,
    input  logic [31:0]             next_stamp,
    input  logic [31:0]             head_value,
    input  logic [COUNT_WIDTH-1:0]  head_count,
    input  logic [31:0]             head_stamp,
    input  logic [31:0]             new_value,
    input  logic [COUNT_WIDTH-1:0]  new_count,
    input  logic [31:0]             new_stamp,
    output logic [31:0]             value,
    output logic [COUNT_WIDTH-1:0]  count,
    output logic [31:0]             stamp
);

    logic [31:0]            value_reg, value_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [31:0]            stamp_reg, stamp_next;

    // Pick the source of this slot's entry
    always_comb
    begin
        value_next = value_reg;
        count_next = count_reg;
        stamp_next = stamp_reg;
        unique case (cmd)
            fol_pkg::CMD_HOLD:
            begin
                value_next = value_reg;
            end
            fol_pkg::CMD_FROM_PREV:
            begin
                value_next = prev_value;
                count_next = prev_count;
                stamp_next = prev_stamp;
            end
            fol_pkg::CMD_FROM_NEXT:
            begin
                value_next = next_value;
                count_next = next_count;
                stamp_next = next_stamp;
            end
            fol_pkg::CMD_FROM_HEAD:
            begin
                value_next = head_value;
                count_next = head_count;
                stamp_next = head_stamp;
            end
            fol_pkg::CMD_FROM_NEW:
            begin
                value_next = new_value;
                count_next = new_count;
                stamp_next = new_stamp;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    // Hold the entry
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        count_reg <= count_next;
        stamp_reg <= stamp_next;
    end

    assign value = value_reg;
    assign count = count_reg;
    assign stamp = stamp_reg;

endmodule

// ===== rtl/fol_ctrl.sv =====
module fol_ctrl #(
    parameter int LIST_DEPTH  = 64,
    parameter int COUNT_WIDTH = 16,
    parameter int IW          = 6,
    parameter int UW          = 7
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [1:0]              opcode,
    input  logic [31:0]             item_value,
    output logic                    busy,
    input  logic [31:0]             head_value,
    input  logic [COUNT_WIDTH-1:0]  head_count,
    input  logic [31:0]             head_stamp,
    input  logic [COUNT_WIDTH-1:0]  second_count,
    input  logic [31:0]             second_stamp,
    output fol_pkg::chain_op_t      chain_op,
    output logic [UW-1:0]           used,
    output logic [IW-1:0]           f_idx,
    output logic [IW-1:0]           p_idx,
    output logic [31:0]             new_value,
    output logic [COUNT_WIDTH-1:0]  new_count,
    output logic [31:0]             new_stamp,
    output fol_pkg::result_t        result
);

    fol_pkg::state_t        state_reg, state_next;
    logic [UW-1:0]          used_reg, used_next;
    logic [31:0]            seq_reg, seq_next;
    logic [IW-1:0]          k_reg, k_next;
    logic [IW-1:0]          f_reg, f_next;
    logic [IW-1:0]          p_reg, p_next;
    logic                   found_reg, found_next;
    logic                   placed_reg, placed_next;
    logic [31:0]            key_reg, key_next;
    logic [COUNT_WIDTH-1:0] c_reg, c_next;
    logic [31:0]            s_reg, s_next;
    fol_pkg::result_t       result_reg, result_next;

    logic [31:0]            k32, n32, f32, lim32;
    logic                   k_last;
    logic                   hit;
    logic [IW-1:0]          f_now;
    logic [COUNT_WIDTH-1:0] cand_count;
    logic [31:0]            cand_stamp;
    logic                   cand_fail;

    assign k32    = 32'(k_reg);
    assign n32    = 32'(used_reg);
    assign f32    = 32'(f_reg);
    assign lim32  = (n32 < 32'(fol_pkg::MAX_OUT)) ? n32 : 32'(fol_pkg::MAX_OUT);
    assign k_last = (k32 + 32'd1 == n32);

    // Head comparison while the list rotates
    assign hit   = !found_reg && (head_value == key_reg);
    assign f_now = found_reg ? f_reg : k_reg;

    // Entry at compacted position k: skip the one being moved
    assign cand_count = (k32 < f32) ? head_count : second_count;
    assign cand_stamp = (k32 < f32) ? head_stamp : second_stamp;
    assign cand_fail  = !((c_reg < cand_count) ||
                          ((c_reg == cand_count) && (s_reg >= cand_stamp)));

    // Next state, chain command and result
    always_comb
    begin
        state_next  = state_reg;
        used_next   = used_reg;
        seq_next    = seq_reg;
        k_next      = k_reg;
        f_next      = f_reg;
        p_next      = p_reg;
        found_next  = found_reg;
        placed_next = placed_reg;
        key_next    = key_reg;
        c_next      = c_reg;
        s_next      = s_reg;
        result_next = '0;
        chain_op    = fol_pkg::OP_HOLD;
        new_value   = key_reg;
        new_count   = c_reg;
        new_stamp   = s_reg;

        unique case (state_reg)
            fol_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    unique case (opcode)
                        fol_pkg::OPC_LOAD:
                        begin
                            result_next.valid = 1'b1;
                            result_next.value = item_value;
                            result_next.last  = 1'b1;
                            if (n32 >= 32'(LIST_DEPTH))
                            begin
                                result_next.status = fol_pkg::STS_FULL;
                            end
                            else
                            begin
                                chain_op             = fol_pkg::OP_LOAD;
                                new_value            = item_value;
                                new_count            = '0;
                                new_stamp            = '0;
                                used_next            = UW'(n32 + 32'd1);
                                result_next.status   = fol_pkg::STS_OK;
                                result_next.position = 6'(used_reg);
                            end
                        end
                        fol_pkg::OPC_ACCESS:
                        begin
                            if (used_reg == '0)
                            begin
                                result_next.valid  = 1'b1;
                                result_next.status = fol_pkg::STS_MISS;
                                result_next.value  = item_value;
                                result_next.last   = 1'b1;
                            end
                            else
                            begin
                                key_next   = item_value;
                                k_next     = '0;
                                found_next = 1'b0;
                                state_next = fol_pkg::ST_FIND;
                            end
                        end
                        fol_pkg::OPC_DUMP:
                        begin
                            if (used_reg == '0)
                            begin
                                result_next.valid  = 1'b1;
                                result_next.status = fol_pkg::STS_EMPTY;
                                result_next.last   = 1'b1;
                            end
                            else
                            begin
                                k_next     = '0;
                                state_next = fol_pkg::ST_DUMP;
                            end
                        end
                        default:
                        begin
                            state_next = fol_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            fol_pkg::ST_FIND:
            begin
                chain_op = fol_pkg::OP_ROTATE;
                // Take the first hit and work out its new count and stamp
                if (hit)
                begin
                    found_next = 1'b1;
                    f_next     = k_reg;
                    c_next     = (head_count == '1) ? head_count
                                                    : head_count + COUNT_WIDTH'(1);
                    if (head_count == '0)
                    begin
                        s_next   = seq_reg;
                        seq_next = (seq_reg == '1) ? seq_reg : seq_reg + 32'd1;
                    end
                    else
                    begin
                        s_next = head_stamp;
                    end
                end
                if (k_last)
                begin
                    k_next = '0;
                    if (found_reg || hit)
                    begin
                        if (f_now == '0)
                        begin
                            p_next     = '0;
                            state_next = fol_pkg::ST_PLACE;
                        end
                        else
                        begin
                            placed_next = 1'b0;
                            state_next  = fol_pkg::ST_SEEK;
                        end
                    end
                    else
                    begin
                        result_next.valid  = 1'b1;
                        result_next.status = fol_pkg::STS_MISS;
                        result_next.value  = key_reg;
                        result_next.last   = 1'b1;
                        state_next         = fol_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    k_next = k_reg + IW'(1);
                end
            end

            fol_pkg::ST_SEEK:
            begin
                chain_op = fol_pkg::OP_ROTATE;
                // Stop at the first entry the moved one may not pass
                if (!placed_reg && (k32 + 32'd2 <= n32) && cand_fail)
                begin
                    placed_next = 1'b1;
                    p_next      = k_reg;
                end
                if (k_last)
                begin
                    k_next     = '0;
                    state_next = fol_pkg::ST_PLACE;
                    if (!placed_reg)
                    begin
                        p_next = k_reg;
                    end
                end
                else
                begin
                    k_next = k_reg + IW'(1);
                end
            end

            fol_pkg::ST_PLACE:
            begin
                chain_op             = fol_pkg::OP_PLACE;
                result_next.valid    = 1'b1;
                result_next.status   = fol_pkg::STS_OK;
                result_next.value    = key_reg;
                result_next.count    = 16'(c_reg);
                result_next.position = 6'(p_reg);
                result_next.last     = 1'b1;
                state_next           = fol_pkg::ST_IDLE;
            end

            fol_pkg::ST_DUMP:
            begin
                chain_op = fol_pkg::OP_ROTATE;
                // Emit the head entry while within the output limit
                if (k32 < lim32)
                begin
                    result_next.valid    = 1'b1;
                    result_next.status   = fol_pkg::STS_OK;
                    result_next.value    = head_value;
                    result_next.count    = 16'(head_count);
                    result_next.position = 6'(k_reg);
                    result_next.last     = (k32 + 32'd1 == lim32);
                end
                if (k_last)
                begin
                    k_next     = '0;
                    state_next = fol_pkg::ST_IDLE;
                end
                else
                begin
                    k_next = k_reg + IW'(1);
                end
            end

            default:
            begin
                state_next = fol_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= fol_pkg::ST_IDLE;
            used_reg   <= '0;
            seq_reg    <= '0;
            found_reg  <= 1'b0;
            placed_reg <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            seq_reg    <= seq_next;
            found_reg  <= found_next;
            placed_reg <= placed_next;
            result_reg <= result_next;
        end
    end

    // Working payload
    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        f_reg   <= f_next;
        p_reg   <= p_next;
        key_reg <= key_next;
        c_reg   <= c_next;
        s_reg   <= s_next;
    end

    assign busy   = (state_reg != fol_pkg::ST_IDLE);
    assign used   = used_reg;
    assign f_idx  = f_reg;
    assign p_idx  = p_reg;
    assign result = result_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(used_reg) <= 32'(LIST_DEPTH))
        else $error("fill count above list depth");

    a_busy_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != fol_pkg::ST_IDLE) |-> (used_reg != '0))
        else $error("working on an empty list");

    a_seek_not_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fol_pkg::ST_SEEK) |-> (f_reg != '0))
        else $error("seeking a place for the head entry");

    a_place_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fol_pkg::ST_PLACE) |=> (state_reg == fol_pkg::ST_IDLE))
        else $error("placement did not finish the access");

    a_load_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode == fol_pkg::OPC_LOAD) &&
         (32'(used_reg) < 32'(LIST_DEPTH)))
        |=> (32'(used_reg) == 32'($past(used_reg)) + 32'd1))
        else $error("load did not grow the list");

endmodule

// ===== rtl/frequency_ordered_list.sv =====
// Channel   Direction  Signals                                    Transfer
// command   in         start, busy, opcode, item_value            start && !busy
// result    out        strobe, status, entry_out_value,           strobe
//                      entry_out_count, entry_position, last
//
// Load, an access to an empty list and a dump of an empty list are answered
// from idle without raising busy. An access rotates the n-entry cell chain
// once to find the entry, a miss ends there; a hit at the head goes to the
// placement, any other hit rotates the chain again to find its new place first.
// A dump rotates the chain once, one result per cycle from the head.
// Reset clears the fill count and stamp counter; entries need no clearing.
// busy stays high until the last result; results cannot be stalled.
module frequency_ordered_list #(
    parameter int LIST_DEPTH  = 64,
    parameter int COUNT_WIDTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] item_value,
    output logic               strobe,
    output logic [1:0]         status,
    output logic signed [31:0] entry_out_value,
    output logic [15:0]        entry_out_count,
    output logic [5:0]         entry_position,
    output logic               last
);

    localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int UW = $clog2(LIST_DEPTH + 1);

    fol_pkg::chain_op_t     chain_op;
    fol_pkg::result_t       result;
    logic [UW-1:0]          used;
    logic [IW-1:0]          f_idx;
    logic [IW-1:0]          p_idx;
    logic [31:0]            new_value;
    logic [COUNT_WIDTH-1:0] new_count;
    logic [31:0]            new_stamp;
    logic [31:0]            n32, f32, p32;

    logic [31:0]            cell_value [LIST_DEPTH];
    logic [COUNT_WIDTH-1:0] cell_count [LIST_DEPTH];
    logic [31:0]            cell_stamp [LIST_DEPTH];
    fol_pkg::cell_cmd_t     cell_cmd   [LIST_DEPTH];

    // Second slot is the head when the list has a single slot
    localparam int SECOND = (LIST_DEPTH > 1) ? 1 : 0;

    fol_ctrl #(
        .LIST_DEPTH  (LIST_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH),
        .IW          (IW),
        .UW          (UW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .opcode       (opcode),
        .item_value   (32'(unsigned'(item_value))),
        .busy         (busy),
        .head_value   (cell_value[0]),
        .head_count   (cell_count[0]),
        .head_stamp   (cell_stamp[0]),
        .second_count (cell_count[SECOND]),
        .second_stamp (cell_stamp[SECOND]),
        .chain_op     (chain_op),
        .used         (used),
        .f_idx        (f_idx),
        .p_idx        (p_idx),
        .new_value    (new_value),
        .new_count    (new_count),
        .new_stamp    (new_stamp),
        .result       (result)
    );

    assign n32 = 32'(used);
    assign f32 = 32'(f_idx);
    assign p32 = 32'(p_idx);

    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        localparam int PREV = (i == 0) ? 0 : i - 1;
        localparam int NEXT = (i == LIST_DEPTH - 1) ? 0 : i + 1;

        // Decode the chain command for this slot
        always_comb
        begin
            cell_cmd[i] = fol_pkg::CMD_HOLD;
            unique case (chain_op)
                fol_pkg::OP_HOLD:
                begin
                    cell_cmd[i] = fol_pkg::CMD_HOLD;
                end
                fol_pkg::OP_ROTATE:
                begin
                    if (32'(i) + 32'd1 < n32)
                    begin
                        cell_cmd[i] = fol_pkg::CMD_FROM_NEXT;
                    end
                    else if (32'(i) + 32'd1 == n32)
                    begin
                        cell_cmd[i] = fol_pkg::CMD_FROM_HEAD;
                    end
                end
                fol_pkg::OP_LOAD:
                begin
                    if (32'(i) == n32)
                    begin
                        cell_cmd[i] = fol_pkg::CMD_FROM_NEW;
                    end
                end
                fol_pkg::OP_PLACE:
                begin
                    if (32'(i) == p32)
                    begin
                        cell_cmd[i] = fol_pkg::CMD_FROM_NEW;
                    end
                    else if ((p32 < f32) && (32'(i) > p32) && (32'(i) <= f32))
                    begin
                        cell_cmd[i] = fol_pkg::CMD_FROM_PREV;
                    end
                    else if ((p32 > f32) && (32'(i) >= f32) && (32'(i) < p32))
                    begin
                        cell_cmd[i] = fol_pkg::CMD_FROM_NEXT;
                    end
                end
                default:
                begin
                    cell_cmd[i] = fol_pkg::CMD_HOLD;
                end
            endcase
        end

        fol_cell #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_cell (
            .clk        (clk),
            .cmd        (cell_cmd[i]),
            .prev_value (cell_value[PREV]),
            .prev_count (cell_count[PREV]),
            .prev_stamp (cell_stamp[PREV]),
            .next_value (cell_value[NEXT]),
            .next_count (cell_count[NEXT]),
            .next_stamp (cell_stamp[NEXT]),
            .head_value (cell_value[0]),
            .head_count (cell_count[0]),
            .head_stamp (cell_stamp[0]),
            .new_value  (new_value),
            .new_count  (new_count),
            .new_stamp  (new_stamp),
            .value      (cell_value[i]),
            .count      (cell_count[i]),
            .stamp      (cell_stamp[i])
        );
    end

    // Drive the result ports
    assign strobe          = result.valid;
    assign status          = result.status;
    assign entry_out_value = signed'(result.value);
    assign entry_out_count = result.count;
    assign entry_position  = result.position;
    assign last            = result.last;

endmodule

// ===== sim/fol_checker.sv =====
module fol_checker #(
    parameter int DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  opcode,
    input  logic [31:0] item_value,
    input  logic        strobe,
    input  logic [1:0]  status,
    input  logic [31:0] entry_out_value,
    input  logic [15:0] entry_out_count,
    input  logic [5:0]  entry_position,
    input  logic        last,
    output int          errors,
    output int          outstanding,
    output int          results_checked
);

    localparam logic [15:0] COUNT_MAX = '1;
    localparam logic [31:0] STAMP_MAX = '1;

    // One list entry as the block keeps it
    typedef struct packed {
        logic [31:0] value;
        logic [15:0] hits;
        logic [31:0] stamp;
    } slot_t;

    // One result the block must give
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value;
        logic [15:0] hits;
        logic [5:0]  pos;
        logic        last;
    } entry_rec_t;

    slot_t       list_slots[$];
    entry_rec_t  due_entries[$];
    logic [31:0] next_stamp;

    initial
    begin
        errors          = 0;
        outstanding     = 0;
        results_checked = 0;
        next_stamp      = '0;
    end

    function automatic entry_rec_t make_rec(logic [1:0] st, logic [31:0] val,
                                            logic [15:0] hits, int pos, logic lst);
        entry_rec_t rec;
        rec.status = st;
        rec.value  = val;
        rec.hits   = hits;
        rec.pos    = pos[5:0];
        rec.last   = lst;
        return rec;
    endfunction

    // Update the list for one command and queue the results it gives
    function automatic void apply_to_list(logic [1:0] op, logic [31:0] val);
        slot_t moved;
        int    idx;
        int    pos;
        int    shown;
        case (op)
            fol_pkg::OPC_LOAD:
            begin
                if (list_slots.size() >= DEPTH)
                begin
                    due_entries.push_back(make_rec(fol_pkg::STS_FULL, val, '0, 0, 1'b1));
                end
                else
                begin
                    moved.value = val;
                    moved.hits  = '0;
                    moved.stamp = '0;
                    list_slots.push_back(moved);
                    due_entries.push_back(make_rec(fol_pkg::STS_OK, val, '0,
                                                   list_slots.size() - 1, 1'b1));
                end
            end
            fol_pkg::OPC_ACCESS:
            begin
                idx = 0;
                while (idx < list_slots.size() && list_slots[idx].value != val)
                    idx++;
                if (idx >= list_slots.size())
                begin
                    due_entries.push_back(make_rec(fol_pkg::STS_MISS, val, '0, 0, 1'b1));
                end
                else
                begin
                    moved = list_slots[idx];
                    // stamp the entry on its first hit
                    if (moved.hits == '0)
                    begin
                        moved.stamp = next_stamp;
                        if (next_stamp != STAMP_MAX)
                            next_stamp++;
                    end
                    if (moved.hits != COUNT_MAX)
                        moved.hits++;
                    pos = 0;
                    if (idx != 0)
                    begin
                        // pull the entry and walk past higher or earlier-stamped equals
                        list_slots.delete(idx);
                        while (pos < list_slots.size() &&
                               (moved.hits < list_slots[pos].hits ||
                                (moved.hits == list_slots[pos].hits &&
                                 moved.stamp >= list_slots[pos].stamp)))
                            pos++;
                        list_slots.insert(pos, moved);
                    end
                    else
                    begin
                        list_slots[0] = moved;
                    end
                    due_entries.push_back(make_rec(fol_pkg::STS_OK, val, moved.hits,
                                                   pos, 1'b1));
                end
            end
            fol_pkg::OPC_DUMP:
            begin
                shown = (list_slots.size() < fol_pkg::MAX_OUT) ? list_slots.size()
                                                               : fol_pkg::MAX_OUT;
                if (shown == 0)
                    due_entries.push_back(make_rec(fol_pkg::STS_EMPTY, '0, '0, 0, 1'b1));
                for (int i = 0; i < shown; i++)
                    due_entries.push_back(make_rec(fol_pkg::STS_OK, list_slots[i].value,
                                                   list_slots[i].hits, i,
                                                   i == shown - 1));
            end
            default:
            begin
                // unused opcode: no result, no change
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    // Compare each result transfer, then predict for the command taken at this edge
    always @(posedge clk)
    begin : watch
        entry_rec_t want;
        if (!rst_n)
        begin
            list_slots.delete();
            due_entries.delete();
            next_stamp = '0;
        end
        else
        begin
            if (strobe === 1'b1)
            begin
                if (due_entries.size() == 0)
                begin
                    errors++;
                    $error("unexpected result: status %0d value %0d position %0d",
                           status, entry_out_value, entry_position);
                end
                else
                begin
                    want = due_entries.pop_front();
                    results_checked++;
                    check_field("status", want.status, status);
                    check_field("entry_out_value", want.value, entry_out_value);
                    check_field("entry_out_count", want.hits, entry_out_count);
                    check_field("entry_position", want.pos, entry_position);
                    check_field("last", want.last, last);
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                apply_to_list(opcode, item_value);
        end
        outstanding = due_entries.size();
    end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;

    localparam int DEPTH         = 64;
    localparam int RANDOM_ITEMS  = 300;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 200;

    localparam logic [1:0]  OPC_UNUSED = 2'd3;
    localparam logic [31:0] VAL_MIN    = 32'h8000_0000;
    localparam logic [31:0] VAL_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] VAL_ONES   = 32'hFFFF_FFFF;

    logic               clk;
    logic               rst_n      = 1'b0;
    logic               start      = 1'b0;
    logic [1:0]         opcode     = fol_pkg::OPC_LOAD;
    logic signed [31:0] item_value = '0;
    logic               busy;
    logic               strobe;
    logic [1:0]         status;
    logic signed [31:0] entry_out_value;
    logic [15:0]        entry_out_count;
    logic [5:0]         entry_position;
    logic               last;

    int errors;
    int outstanding;
    int results_checked;

    // Values held in the list, in load order, for picking hits
    logic [31:0] stored_values[$];
    int          n_loads     = 0;
    int          n_accesses  = 0;
    int          n_dumps     = 0;
    int          quiet_count = 0;
    int          burst_left  = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    frequency_ordered_list #(
        .LIST_DEPTH  (DEPTH),
        .COUNT_WIDTH (16)
    ) DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .opcode          (opcode),
        .item_value      (item_value),
        .strobe          (strobe),
        .status          (status),
        .entry_out_value (entry_out_value),
        .entry_out_count (entry_out_count),
        .entry_position  (entry_position),
        .last            (last)
    );

    fol_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .opcode          (opcode),
        .item_value      (item_value),
        .strobe          (strobe),
        .status          (status),
        .entry_out_value (entry_out_value),
        .entry_out_count (entry_out_count),
        .entry_position  (entry_position),
        .last            (last),
        .errors          (errors),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    // Hold a command until the block takes it; return at the next falling edge
    task automatic send(logic [1:0] op, logic [31:0] val);
        start      <= 1'b1;
        opcode     <= op;
        item_value <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        case (op)
            fol_pkg::OPC_LOAD:
            begin
                n_loads++;
                if (stored_values.size() < DEPTH)
                    stored_values.push_back(val);
            end
            fol_pkg::OPC_ACCESS: n_accesses++;
            fol_pkg::OPC_DUMP:   n_dumps++;
            default:    ;
        endcase
    endtask

    task automatic rest(int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(negedge clk);
        end
    endtask

    // Drop start and wait until every expected result has come back
    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (outstanding != 0 || busy)
            @(negedge clk);
    endtask

    // Mostly short gaps, a few long ones, and bursts with none
    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if (r < 8)
        begin
            burst_left = $urandom_range(10, 30);
            return 0;
        end
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // End the run if no transfer happens for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || strobe)
                quiet_count = 0;
            else
                quiet_count++;
            if (quiet_count >= QUIET_LIMIT)
            begin
                $error("no transfer for %0d cycles, %0d results still due",
                       QUIET_LIMIT, outstanding);
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int          counted;
        int          pick;
        logic [31:0] val;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty list: dump and access
        send(fol_pkg::OPC_DUMP, VAL_ONES);
        send(fol_pkg::OPC_ACCESS, '0);
        // loads of the extreme values, first hit moves ahead
        send(fol_pkg::OPC_LOAD, VAL_MIN);
        send(fol_pkg::OPC_LOAD, VAL_MAX);
        send(fol_pkg::OPC_ACCESS, VAL_MAX);
        // equal count, later stamp stays behind
        rest(2);
        send(fol_pkg::OPC_ACCESS, VAL_MIN);
        send(fol_pkg::OPC_ACCESS, VAL_ONES);
        send(OPC_UNUSED, VAL_ONES);
        send(fol_pkg::OPC_DUMP, '0);

        // trade the head between two entries, back to back; equal counts
        // let the earlier stamp win
        repeat (12) send(fol_pkg::OPC_ACCESS, VAL_MIN);
        repeat (12) send(fol_pkg::OPC_ACCESS, VAL_MAX);
        send(fol_pkg::OPC_ACCESS, VAL_MIN);
        send(fol_pkg::OPC_ACCESS, VAL_MAX);

        // duplicate value: access hits the first copy
        send(fol_pkg::OPC_LOAD, VAL_MIN);
        send(fol_pkg::OPC_ACCESS, VAL_MIN);
        send(fol_pkg::OPC_LOAD, '0);
        rest(5);
        send(fol_pkg::OPC_LOAD, VAL_ONES);
        send(fol_pkg::OPC_ACCESS, VAL_ONES);
        send(fol_pkg::OPC_ACCESS, '0);
        send(fol_pkg::OPC_DUMP, VAL_MIN);
        drain();

        // random part: mostly hits on known values, loads until full
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 99) < 3)
                drain();
            else
                rest(next_gap());
            pick = $urandom_range(0, 99);
            if (pick < 18)
            begin
                if ($urandom_range(0, 7) == 0)
                    val = stored_values[$urandom_range(0, stored_values.size() - 1)];
                else
                    val = $urandom();
                send(fol_pkg::OPC_LOAD, val);
                counted++;
            end
            else if (pick < 68)
            begin
                send(fol_pkg::OPC_ACCESS,
                     stored_values[$urandom_range(0, stored_values.size() - 1)]);
                counted++;
            end
            else if (pick < 80)
            begin
                send(fol_pkg::OPC_ACCESS, $urandom());
                counted++;
            end
            else if (pick < 92)
            begin
                send(fol_pkg::OPC_DUMP, $urandom());
                counted++;
            end
            else
            begin
                send(OPC_UNUSED, $urandom());
            end
        end

        // fill the list, overflow it, hit the tail, dump all
        while (stored_values.size() < DEPTH)
        begin
            rest(next_gap());
            send(fol_pkg::OPC_LOAD, $urandom());
        end
        send(fol_pkg::OPC_LOAD, VAL_MAX);
        send(fol_pkg::OPC_LOAD, $urandom());
        rest(next_gap());
        send(fol_pkg::OPC_ACCESS, stored_values[DEPTH - 1]);
        send(fol_pkg::OPC_DUMP, '0);

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("tb_top: sent %0d loads, %0d accesses, %0d dumps; %0d results checked",
                 n_loads, n_accesses, n_dumps, results_checked);
        $display("tb_top: list filled to %0d entries, head traded on equal counts",
                 stored_values.size());
        if (errors == 0 && outstanding == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/fol_pkg.sv
rtl/fol_cell.sv
rtl/fol_ctrl.sv
rtl/frequency_ordered_list.sv
sim/fol_checker.sv
sim/tb_top.sv
